[hdl/sktbl_pkg.sv]
// shared types, codes and constants of the sorted key value table
package sktbl_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 16;
   localparam int KEY_W = 32;
   localparam int DATA_W = 32;
   localparam int STATUS_W = 2;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;

   typedef struct packed {
      logic                     command;
      logic signed [KEY_W-1:0]  key;
      logic signed [DATA_W-1:0] write_data;
   } req_word_type;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic signed [DATA_W-1:0] read_data;
   } rsp_word_type;

   // controller to datapath
   typedef struct packed {
      logic                load_item;
      logic                pos_load_count;
      logic                pos_clear;
      logic                pos_dec;
      logic                pos_inc;
      logic                mem_rd;
      logic                rd_prev;
      logic                mem_wr;
      logic                wr_new;
      logic                count_inc;
      logic                res_set;
      logic [STATUS_W-1:0] res_code;
      logic                load_rsp;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_search;
      logic full;
      logic pos_zero;
      logic pos_at_count;
      logic key_gt;
      logic key_lt;
      logic key_eq;
      logic out_busy;
   } dp_stat_type;

endpackage

[hdl/sktbl_datapath.sv]
// datapath: entry memory, walk position, entry count and result registers
module sktbl_datapath #(
   parameter int TABLE_DEPTH = sktbl_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  sktbl_pkg::req_word_type req_word,
   input  sktbl_pkg::ctl_cmd_type  cmd,
   output sktbl_pkg::dp_stat_type  stat,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output sktbl_pkg::rsp_word_type rsp_word
);
   import sktbl_pkg::*;

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int ENTRY_W = KEY_W + DATA_W;

   logic [ENTRY_W-1:0] mem [TABLE_DEPTH];

   req_word_type        item_ff;
   logic [CNT_W-1:0]    pos_ff, pos_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [ENTRY_W-1:0]  rd_word_ff;
   logic [CNT_W-1:0]    rd_pos;
   logic [IDX_W-1:0]    rd_idx, wr_idx;
   logic signed [KEY_W-1:0]  rd_key;
   logic signed [DATA_W-1:0] rd_data;
   logic [STATUS_W-1:0]      res_status_ff;
   logic signed [DATA_W-1:0] res_data_ff, res_data_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_word_type             rsp_word_ff;

   assign rd_key = rd_word_ff[ENTRY_W-1:DATA_W];
   assign rd_data = rd_word_ff[DATA_W-1:0];
   assign rd_pos = cmd.rd_prev ? pos_ff - 1'b1 : pos_ff;
   assign rd_idx = rd_pos[IDX_W-1:0];
   assign wr_idx = pos_ff[IDX_W-1:0];

   always_comb begin
      pos_in = pos_ff;
      if (cmd.pos_load_count) begin
         pos_in = count_ff;
      end else if (cmd.pos_clear) begin
         pos_in = '0;
      end else if (cmd.pos_dec) begin
         pos_in = pos_ff - 1'b1;
      end else if (cmd.pos_inc) begin
         pos_in = pos_ff + 1'b1;
      end
   end

   assign count_in = cmd.count_inc ? count_ff + 1'b1 : count_ff;

   always_comb begin
      if (cmd.res_code == ST_MISS) begin
         res_data_in = '1;
      end else if (cmd.res_code == ST_OK && item_ff.command == CMD_SEARCH) begin
         res_data_in = rd_data;
      end else begin
         res_data_in = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      if (cmd.load_item) begin
         item_ff <= req_word;
      end
      if (cmd.res_set) begin
         res_status_ff <= cmd.res_code;
         res_data_ff <= res_data_in;
      end
      if (cmd.load_rsp) begin
         rsp_word_ff.status <= res_status_ff;
         rsp_word_ff.read_data <= res_data_ff;
      end
   end

   // entry memory: key in the upper half, data in the lower half
   always_ff @(posedge clock) begin
      if (cmd.mem_wr) begin
         mem[wr_idx] <= cmd.wr_new ? {item_ff.key, item_ff.write_data} : rd_word_ff;
      end
      if (cmd.mem_rd) begin
         rd_word_ff <= mem[rd_idx];
      end
   end

   assign stat.is_search = (item_ff.command == CMD_SEARCH);
   assign stat.full = (count_ff == CNT_W'(TABLE_DEPTH));
   assign stat.pos_zero = (pos_ff == '0);
   assign stat.pos_at_count = (pos_ff == count_ff);
   assign stat.key_gt = (rd_key > item_ff.key);
   assign stat.key_lt = (rd_key < item_ff.key);
   assign stat.key_eq = (rd_key == item_ff.key);
   assign stat.out_busy = rsp_valid_ff && rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_word_ff;

endmodule

[hdl/sktbl_control.sv]
// controller: sequences insert shifts and search walks over the datapath
module sktbl_control (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output sktbl_pkg::ctl_cmd_type cmd,
   input  sktbl_pkg::dp_stat_type stat
);
   import sktbl_pkg::*;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DECIDE   = 3'd1;
   localparam logic [2:0] S_INS_RD   = 3'd2;
   localparam logic [2:0] S_INS_CMP  = 3'd3;
   localparam logic [2:0] S_SRCH_RD  = 3'd4;
   localparam logic [2:0] S_SRCH_CMP = 3'd5;
   localparam logic [2:0] S_DONE     = 3'd6;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.res_code = ST_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (stat.is_search) begin
               cmd.pos_clear = 1'b1;
               state_in = S_SRCH_RD;
            end else if (stat.full) begin
               cmd.res_set = 1'b1;
               cmd.res_code = ST_FULL;
               state_in = S_DONE;
            end else begin
               cmd.pos_load_count = 1'b1;
               state_in = S_INS_RD;
            end
         end
         S_INS_RD: begin
            if (stat.pos_zero) begin
               cmd.mem_wr = 1'b1;
               cmd.wr_new = 1'b1;
               cmd.count_inc = 1'b1;
               cmd.res_set = 1'b1;
               state_in = S_DONE;
            end else begin
               cmd.mem_rd = 1'b1;
               cmd.rd_prev = 1'b1;
               state_in = S_INS_CMP;
            end
         end
         S_INS_CMP: begin
            cmd.mem_wr = 1'b1;
            if (stat.key_gt) begin
               // move the larger entry up one slot
               cmd.pos_dec = 1'b1;
               state_in = S_INS_RD;
            end else begin
               cmd.wr_new = 1'b1;
               cmd.count_inc = 1'b1;
               cmd.res_set = 1'b1;
               state_in = S_DONE;
            end
         end
         S_SRCH_RD: begin
            if (stat.pos_at_count) begin
               cmd.res_set = 1'b1;
               cmd.res_code = ST_MISS;
               state_in = S_DONE;
            end else begin
               cmd.mem_rd = 1'b1;
               state_in = S_SRCH_CMP;
            end
         end
         S_SRCH_CMP: begin
            if (stat.key_lt) begin
               cmd.pos_inc = 1'b1;
               state_in = S_SRCH_RD;
            end else begin
               cmd.res_set = 1'b1;
               cmd.res_code = stat.key_eq ? ST_OK : ST_MISS;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!stat.out_busy) begin
               cmd.load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

[hdl/sorted_key_value_table.sv]
// top level of the sorted key value table
//
//   channel | direction | handshake            | word
//   req     | in        | req_valid, req_stall | command, key, write_data
//   rsp     | out       | rsp_valid, rsp_stall | status, read_data
//
// each step of the walk is one read and compare of the single-port entry memory, and a
// walk covers at most the n entries in use. a search stops at the first key not below
// the searched key. reset empties the table by clearing the entry count; entries are
// never cleared. a stalled result holds in the output register; the next word is taken
// after it is loaded.
module sorted_key_value_table #(
   parameter int TABLE_DEPTH = sktbl_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  sktbl_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output sktbl_pkg::rsp_word_type rsp_word
);
   import sktbl_pkg::*;

   ctl_cmd_type cmd;
   dp_stat_type stat;

   sktbl_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   sktbl_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

[hdl/sktbl_checker.sv]
// port checker for the sorted key value table and its bind
module sktbl_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input sktbl_pkg::rsp_word_type rsp_word
);
   import sktbl_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled result changed");

   // one item at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("accepted a word while busy");

   a_miss_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status == ST_MISS |-> rsp_word.read_data == -32'sd1)
      else $error("miss without all-ones data");

   a_full_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status == ST_FULL |-> rsp_word.read_data == 32'sd0)
      else $error("full status with nonzero data");

endmodule

bind sorted_key_value_table sktbl_checker u_sktbl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);

[sim/tb.sv]
// testbench of the sorted key value table: directed and random words checked against a shadow table
`timescale 1ns / 100ps

import sktbl_pkg::*;

class table_shadow;
   logic signed [KEY_W-1:0]  shadow_keys[DEFAULT_TABLE_DEPTH];
   logic signed [DATA_W-1:0] shadow_data[DEFAULT_TABLE_DEPTH];
   int                       shadow_fill;
   rsp_word_type             due_responses[$];
   int                       mismatches;

   function new();
      shadow_fill = 0;
      mismatches = 0;
   endfunction

   function void apply_request(req_word_type w);
      rsp_word_type r;
      int pos;
      r.status = ST_OK;
      r.read_data = '0;
      pos = 0;
      if (w.command == CMD_INSERT) begin
         if (shadow_fill >= DEFAULT_TABLE_DEPTH) begin
            r.status = ST_FULL;
         end else begin
            while (pos < shadow_fill && $signed(shadow_keys[pos]) <= $signed(w.key))
               pos++;
            for (int i = shadow_fill; i > pos; i--) begin
               shadow_keys[i] = shadow_keys[i-1];
               shadow_data[i] = shadow_data[i-1];
            end
            shadow_keys[pos] = w.key;
            shadow_data[pos] = w.write_data;
            shadow_fill++;
         end
      end else begin
         while (pos < shadow_fill && $signed(shadow_keys[pos]) < $signed(w.key))
            pos++;
         if (pos < shadow_fill && shadow_keys[pos] == w.key) begin
            r.read_data = shadow_data[pos];
         end else begin
            r.status = ST_MISS;
            r.read_data = '1;
         end
      end
      due_responses.push_back(r);
   endfunction

   function void flag(string what, rsp_word_type exp, rsp_word_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("%s: expected status %0d data %0d, got status %0d data %0d",
                  what, exp.status, exp.read_data, got.status, got.read_data);
   endfunction

   function void match_response(rsp_word_type got);
      rsp_word_type exp;
      if (due_responses.size() == 0) begin
         flag("word with none due", '0, got);
      end else begin
         exp = due_responses.pop_front();
         if (got.status !== exp.status || got.read_data !== exp.read_data)
            flag("wrong word", exp, got);
      end
   endfunction
endclass

module tb;

   localparam int CYCLE_LIMIT = 800000;
   localparam int DRAIN_CYCLES = 2 * DEFAULT_TABLE_DEPTH + 8;
   localparam int HOLD_CYCLES = 400;
   localparam logic signed [KEY_W-1:0] MIN_KEY = 32'sh8000_0000;
   localparam logic signed [KEY_W-1:0] MAX_KEY = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] ALL_ONES = '1;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_left = 0;
   int cycle_count = 0;

   table_shadow sb = new();

   sorted_key_value_table dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.apply_request(req_word);
         if (rsp_valid && !rsp_stall)
            sb.match_response(rsp_word);
      end
   end

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic send_word(input req_word_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      @(negedge clock);
   endtask

   function automatic req_word_type next_request();
      req_word_type w;
      int pick;
      int idx;
      w.command = ($urandom_range(99) < 20) ? CMD_INSERT : CMD_SEARCH;
      w.write_data = $urandom;
      w.key = $urandom;
      pick = $urandom_range(9);
      if (sb.shadow_fill > 0 && pick < 7) begin
         idx = $urandom_range(sb.shadow_fill - 1);
         w.key = sb.shadow_keys[idx];
         if (pick >= 5)
            w.key = w.key + (($urandom_range(1) == 1) ? 32'sd1 : -32'sd1);
      end
      return w;
   endfunction

   task automatic run_random(input int count);
      repeat (count)
         send_word(next_request());
   endtask

   task automatic set_phase(input int idle, input int stall);
      req_valid <= 1'b0;
      @(posedge clock);
      send_idle_pct = idle;
      stall_pct = stall;
      @(negedge clock);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty table, extremes, equal keys, stored data of all ones
      send_word('{CMD_SEARCH, 32'sd5, 32'sd0});
      send_word('{CMD_INSERT, MAX_KEY, MAX_KEY});
      send_word('{CMD_INSERT, MIN_KEY, MIN_KEY});
      send_word('{CMD_INSERT, 32'sd0, ALL_ONES});
      send_word('{CMD_INSERT, 32'sd5, 32'sd1});
      send_word('{CMD_INSERT, 32'sd5, 32'sd2});
      send_word('{CMD_INSERT, 32'sd5, ALL_ONES});
      send_word('{CMD_INSERT, -32'sd5, 32'sd3});
      send_word('{CMD_SEARCH, 32'sd5, ALL_ONES});
      send_word('{CMD_SEARCH, 32'sd0, 32'sd0});
      send_word('{CMD_SEARCH, MIN_KEY, 32'sd0});
      send_word('{CMD_SEARCH, MAX_KEY, 32'sd0});
      send_word('{CMD_SEARCH, 32'sd4, 32'sd0});
      send_word('{CMD_SEARCH, 32'sd6, 32'sd0});
      // fill the table, then one more
      send_word('{CMD_INSERT, -32'sd1, 32'sd10});
      send_word('{CMD_INSERT, 32'sd1, 32'sd11});
      send_word('{CMD_INSERT, MAX_KEY, 32'sd12});
      send_word('{CMD_INSERT, MIN_KEY, 32'sd13});
      send_word('{CMD_INSERT, 32'sd5, 32'sd14});
      send_word('{CMD_INSERT, 32'sh0000_FFFF, 32'sd15});
      send_word('{CMD_INSERT, 32'shFFFF_F000, 32'sd16});
      send_word('{CMD_INSERT, 32'sh1234_5678, 32'sd17});
      send_word('{CMD_INSERT, -32'sd100, 32'sd18});
      send_word('{CMD_INSERT, 32'sd7, 32'sd19});
      send_word('{CMD_SEARCH, MAX_KEY, 32'sd0});

      // long receiver hold so the table backs up into the input
      fork
         begin
            @(posedge clock);
            hold_left = HOLD_CYCLES;
         end
         run_random(300);
      join
      set_phase(75, 0);
      run_random(275);
      set_phase(0, 75);
      run_random(275);
      set_phase(8, 8);
      run_random(275);

      req_valid <= 1'b0;
      while (sb.due_responses.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.due_responses.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

[filelist.f]
hdl/sktbl_pkg.sv
hdl/sktbl_datapath.sv
hdl/sktbl_control.sv
hdl/sorted_key_value_table.sv
hdl/sktbl_checker.sv
sim/tb.sv
